// ===== rtl/tlfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlfs_pkg: shared types for the two-level FCFS scheduler
// Field widths, the stored job entry and the candidate record.
// ----------------------------------------------------------------------------
package tlfs_pkg;

    localparam int BURST_W = 16;
    localparam int ARR_W   = 16;
    localparam int TIME_W  = 23;
    localparam int ID_W    = 7;

    // one stored job
    typedef struct packed {
        logic               user_class;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // best job seen so far in a scan
    typedef struct packed {
        logic   found;
        t_entry ent;
    } t_cand;

endpackage
`default_nettype wire

// ===== rtl/tlfs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlfs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module tlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/tlfs_pick.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlfs_pick: running selection over one scan of the job store
// Tracks the best ready job (class, then arrival) and the earliest
// pending job (arrival, then class); ties keep the lower index.
// ----------------------------------------------------------------------------
module tlfs_pick
    import tlfs_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic              i_vld,
    input  wire logic              i_skip,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire t_entry            i_ent,
    input  wire logic [TIME_W-1:0] i_clock,
    output t_cand                  o_ready,
    output logic [IDX_W-1:0]       o_ready_idx,
    output t_cand                  o_pend,
    output logic [IDX_W-1:0]       o_pend_idx
);

    t_cand            r_ready;
    t_cand            r_pend;
    logic [IDX_W-1:0] r_ready_idx;
    logic [IDX_W-1:0] r_pend_idx;

    logic             w_live;
    logic             w_arrived;
    logic             w_ready_better;
    logic             w_pend_better;

    assign w_live    = i_vld && !i_skip;
    assign w_arrived = {{(TIME_W-ARR_W){1'b0}}, i_ent.arrival} <= i_clock;

    assign w_ready_better = !r_ready.found
        || (i_ent.user_class < r_ready.ent.user_class)
        || ((i_ent.user_class == r_ready.ent.user_class)
            && (i_ent.arrival < r_ready.ent.arrival));

    assign w_pend_better = !r_pend.found
        || (i_ent.arrival < r_pend.ent.arrival)
        || ((i_ent.arrival == r_pend.ent.arrival)
            && (i_ent.user_class < r_pend.ent.user_class));

    // found flags reset; payload side has no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ready.found <= 1'b0;
            r_pend.found  <= 1'b0;
        end else begin
            if (w_live && w_arrived && w_ready_better) begin
                r_ready.found <= 1'b1;
            end
            if (w_live && w_pend_better) begin
                r_pend.found <= 1'b1;
            end
        end
        if (w_live && w_arrived && w_ready_better) begin
            r_ready.ent <= i_ent;
            r_ready_idx <= i_idx;
        end
        if (w_live && w_pend_better) begin
            r_pend.ent <= i_ent;
            r_pend_idx <= i_idx;
        end
    end

    assign o_ready     = r_ready;
    assign o_ready_idx = r_ready_idx;
    assign o_pend      = r_pend;
    assign o_pend_idx  = r_pend_idx;

endmodule
`default_nettype wire

// ===== rtl/two_level_fcfs_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_fcfs_scheduler_unit: non-preemptive two-level FCFS scheduler
// Loads a set of jobs into RAM, then emits one word per job in run order.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------
//   in      | i_in_valid / o_in_stall | burst, arrival, user_class, last_job
//   out     | o_out_valid/ i_out_stall| job_id, start/end_time, waiting,
//           |                         | turnaround, response, last_result
//
// Loading takes one input word per cycle. Once the last job is in, every
// decision is one full scan of all jobs in the set through the job RAM's
// single registered read port, then the finish state commits the pick.
// Reset clears control only; the job RAM needs no clearing pass.
// The input stalls from the last job until the final result is registered;
// a stalled output word holds while the next scan already runs.
// ----------------------------------------------------------------------------
module two_level_fcfs_scheduler_unit
    import tlfs_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [BURST_W-1:0] i_burst,
    input  wire logic [ARR_W-1:0]   i_arrival,
    input  wire logic               i_user_class,
    input  wire logic               i_last_job,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [ID_W-1:0]         o_job_id,
    output logic [TIME_W-1:0]       o_start_time,
    output logic [TIME_W-1:0]       o_end_time,
    output logic [TIME_W-1:0]       o_waiting,
    output logic [TIME_W-1:0]       o_turnaround,
    output logic [TIME_W-1:0]       o_response,
    output logic                    o_last_result
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // state codes
    localparam logic [1:0] S_LOAD = 2'd0;  // collecting jobs
    localparam logic [1:0] S_SCAN = 2'd1;  // one pass over the store
    localparam logic [1:0] S_FIN  = 2'd2;  // commit pick, emit word

    logic [1:0]           r_state;
    logic [CNT_W-1:0]     r_count;   // jobs in the set
    logic [CNT_W-1:0]     r_rd_idx;  // next read address
    logic [CNT_W-1:0]     r_k;       // results emitted so far
    logic                 r_rd_vld;  // RAM data valid this cycle
    logic [IDX_W-1:0]     r_rd_pos;  // index of that data
    logic [MAX_PROCS-1:0] r_done;    // jobs already run
    logic [TIME_W-1:0]    r_clock;   // schedule time
    logic                 r_out_valid;

    // write side
    logic                 w_in_fire;
    logic                 w_room;
    logic                 w_we;
    t_entry               w_wr_ent;
    t_entry               w_rd_ent;

    // scan / pick
    logic                 w_issue;
    logic                 w_scan_end;
    logic                 w_clear;
    t_cand                w_ready;
    t_cand                w_pend;
    logic [IDX_W-1:0]     w_ready_idx;
    logic [IDX_W-1:0]     w_pend_idx;

    // finish
    logic                 w_out_free;
    logic                 w_fin_go;
    logic                 w_last;
    t_entry               w_sel;
    logic [IDX_W-1:0]     w_sel_idx;
    logic [TIME_W-1:0]    w_arr_ext;
    logic [TIME_W-1:0]    w_start;
    logic [TIME_W-1:0]    w_end;

    // ---------------------------------------------------------------- load
    assign o_in_stall = (r_state != S_LOAD);
    assign w_in_fire  = i_in_valid && (r_state == S_LOAD);
    assign w_room     = r_count < CNT_W'(MAX_PROCS);
    assign w_we       = w_in_fire && w_room;   // full set: word dropped

    assign w_wr_ent.user_class = i_user_class;
    assign w_wr_ent.arrival    = i_arrival;
    assign w_wr_ent.burst      = i_burst;

    tlfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCS)
    ) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wr_ent),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rd_ent)
    );

    // ---------------------------------------------------------------- scan
    assign w_issue    = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign w_scan_end = (r_state == S_SCAN) && !w_issue && !r_rd_vld;

    // trackers restart for every decision
    assign w_clear = (r_state == S_LOAD) || w_fin_go;

    tlfs_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clear),
        .i_vld       (r_rd_vld),
        .i_skip      (r_done[r_rd_pos]),
        .i_idx       (r_rd_pos),
        .i_ent       (w_rd_ent),
        .i_clock     (r_clock),
        .o_ready     (w_ready),
        .o_ready_idx (w_ready_idx),
        .o_pend      (w_pend),
        .o_pend_idx  (w_pend_idx)
    );

    // -------------------------------------------------------------- finish
    // No job ready at the current time: idle forward to the earliest
    // pending arrival, where the pending tracker already holds the winner.
    assign w_sel     = w_ready.found ? w_ready.ent : w_pend.ent;
    assign w_sel_idx = w_ready.found ? w_ready_idx : w_pend_idx;
    assign w_arr_ext = {{(TIME_W-ARR_W){1'b0}}, w_sel.arrival};
    assign w_start   = w_ready.found ? r_clock : w_arr_ext;
    assign w_end     = w_start + {{(TIME_W-BURST_W){1'b0}}, w_sel.burst};

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fin_go   = (r_state == S_FIN) && w_out_free;
    assign w_last     = (r_k + CNT_W'(1)) == r_count;

    // ------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_done      <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            // new word replaces the old one, or an accepted word leaves
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_we) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (w_in_fire && i_last_job) begin
                        r_state  <= S_SCAN;
                        r_rd_idx <= '0;
                        r_k      <= '0;
                        r_clock  <= '0;
                        r_done   <= '0;
                    end
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_k      <= r_k + CNT_W'(1);
                        r_rd_idx <= '0;
                        if (w_last) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                            r_clock <= '0;
                            r_done  <= '0;
                        end else begin
                            r_state           <= S_SCAN;
                            r_done[w_sel_idx] <= 1'b1;
                            r_clock           <= w_end;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // position of the RAM word that arrives next cycle
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_pos <= r_rd_idx[IDX_W-1:0];
        end
    end

    // output word registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            o_job_id      <= {{(ID_W-IDX_W){1'b0}}, w_sel_idx} + ID_W'(1);
            o_start_time  <= w_start;
            o_end_time    <= w_end;
            o_waiting     <= w_start - w_arr_ext;  // turnaround - burst
            o_turnaround  <= w_end - w_arr_ext;
            o_response    <= w_start - w_arr_ext;
            o_last_result <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------------------------------------------------- assertions
    // some unrun job always exists when a decision is made
    a_pend_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> w_pend.found)
        else $error("no pending job at decision time");

    // the committed job has not run yet in this set
    a_no_rerun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |-> !r_done[w_sel_idx])
        else $error("job scheduled twice");

    // never more results than jobs
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_k < r_count))
        else $error("result count overran set");

    // done flags are clear while loading the next set
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_done == '0))
        else $error("stale done flags during load");

endmodule
`default_nettype wire

// ===== tb/fcfs_schedule_checker.sv =====
// ----------------------------------------------------------------------------
// fcfs_schedule_checker: scoreboard for the two-level FCFS scheduler
// Watches both channels, builds the expected run order of every job set and
// compares each output word with the oldest expected word.
// ----------------------------------------------------------------------------
module fcfs_schedule_checker
    import tlfs_pkg::*;
#(
    parameter int MAX_JOBS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [BURST_W-1:0] i_burst,
    input  wire logic [ARR_W-1:0]   i_arrival,
    input  wire logic               i_user_class,
    input  wire logic               i_last_job,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [ID_W-1:0]    i_job_id,
    input  wire logic [TIME_W-1:0]  i_start_time,
    input  wire logic [TIME_W-1:0]  i_end_time,
    input  wire logic [TIME_W-1:0]  i_waiting,
    input  wire logic [TIME_W-1:0]  i_turnaround,
    input  wire logic [TIME_W-1:0]  i_response,
    input  wire logic               i_last_result,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] response;
        logic              last_result;
    } t_run_word;

    t_entry      job_ram [MAX_JOBS];
    int          jobs_loaded;
    t_run_word   run_order_q [$];
    int          mismatches;
    t_run_word   seen_word;
    t_run_word   want_word;
    t_entry      new_job;

    // non-preemptive pass over the loaded set, system class first,
    // then earliest arrival, then earliest load position
    task automatic plan_run_order();
        logic [MAX_JOBS-1:0] ran;
        logic [TIME_W-1:0]   tick;
        logic [TIME_W-1:0]   fin;
        logic [TIME_W-1:0]   tat;
        logic [ARR_W-1:0]    earliest;
        logic                any_left;
        logic                found;
        int                  best;
        t_run_word           w;
        ran  = '0;
        tick = '0;
        for (int k = 0; k < jobs_loaded; k++) begin
            any_left = 1'b0;
            earliest = '0;
            for (int i = 0; i < jobs_loaded; i++) begin
                if (!ran[i]) begin
                    if (!any_left || job_ram[i].arrival < earliest) begin
                        earliest = job_ram[i].arrival;
                    end
                    any_left = 1'b1;
                end
            end
            // idle forward when nothing has arrived yet
            if (any_left && TIME_W'(earliest) > tick) begin
                tick = TIME_W'(earliest);
            end
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < jobs_loaded; i++) begin
                if (!ran[i] && TIME_W'(job_ram[i].arrival) <= tick) begin
                    if (!found ||
                        job_ram[i].user_class < job_ram[best].user_class ||
                        (job_ram[i].user_class == job_ram[best].user_class &&
                         job_ram[i].arrival < job_ram[best].arrival)) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            fin           = tick + TIME_W'(job_ram[best].burst);
            tat           = fin - TIME_W'(job_ram[best].arrival);
            w.job_id      = ID_W'(best + 1);
            w.start_time  = tick;
            w.end_time    = fin;
            w.turnaround  = tat;
            w.waiting     = tat - TIME_W'(job_ram[best].burst);
            w.response    = tick - TIME_W'(job_ram[best].arrival);
            w.last_result = (k + 1 == jobs_loaded);
            run_order_q.push_back(w);
            ran[best] = 1'b1;
            tick      = fin;
        end
        jobs_loaded = 0;
    endtask

    initial begin
        jobs_loaded  = 0;
        mismatches   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            jobs_loaded = 0;
            run_order_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                new_job.burst      = i_burst;
                new_job.arrival    = i_arrival;
                new_job.user_class = i_user_class;
                // a job beyond a full set is dropped
                if (jobs_loaded < MAX_JOBS) begin
                    job_ram[jobs_loaded] = new_job;
                    jobs_loaded++;
                end
                if (i_last_job) begin
                    plan_run_order();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                seen_word.job_id      = i_job_id;
                seen_word.start_time  = i_start_time;
                seen_word.end_time    = i_end_time;
                seen_word.waiting     = i_waiting;
                seen_word.turnaround  = i_turnaround;
                seen_word.response    = i_response;
                seen_word.last_result = i_last_result;
                if (run_order_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: id %0d start %0d end %0d",
                                 i_job_id, i_start_time, i_end_time);
                    end
                end else begin
                    want_word = run_order_q.pop_front();
                    if (seen_word !== want_word) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch id %0d/%0d start %0d/%0d end %0d/%0d",
                                     want_word.job_id, seen_word.job_id,
                                     want_word.start_time, seen_word.start_time,
                                     want_word.end_time, seen_word.end_time);
                            $display("  wait %0d/%0d tat %0d/%0d resp %0d/%0d last %0b/%0b",
                                     want_word.waiting, seen_word.waiting,
                                     want_word.turnaround, seen_word.turnaround,
                                     want_word.response, seen_word.response,
                                     want_word.last_result, seen_word.last_result);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= run_order_q.size();
    end

endmodule

// ===== tb/tb_two_level_fcfs_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_two_level_fcfs_scheduler_unit: testbench top for the FCFS scheduler
// Drives job sets into the block, stalls the output side at random and lets
// the checker predict and compare every run-order word.
// ----------------------------------------------------------------------------
module tb_two_level_fcfs_scheduler_unit
    import tlfs_pkg::*;
();

    localparam int MAX_JOBS    = 16;
    localparam int JOB_TARGET  = 400;
    // watchdog limit for the whole run; this leaves a wide margin
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
    logic               user_class;
    logic               last_job;
    logic               out_valid;
    logic               out_stall;
    logic [ID_W-1:0]    job_id;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic [TIME_W-1:0]  waiting;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  response;
    logic               last_result;

    int fail_count;
    int pending;
    int cycle_count;
    int jobs_sent;
    int idle_pct;
    int stall_pct;

    // idling phases: none, sender only, receiver only, both
    int idle_by_phase [4]  = '{0, 60, 0, 37};
    int stall_by_phase [4] = '{0, 0, 60, 37};

    two_level_fcfs_scheduler_unit #(
        .MAX_PROCS (MAX_JOBS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_burst       (burst),
        .i_arrival     (arrival),
        .i_user_class  (user_class),
        .i_last_job    (last_job),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_job_id      (job_id),
        .o_start_time  (start_time),
        .o_end_time    (end_time),
        .o_waiting     (waiting),
        .o_turnaround  (turnaround),
        .o_response    (response),
        .o_last_result (last_result)
    );

    fcfs_schedule_checker #(
        .MAX_JOBS (MAX_JOBS)
    ) scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_burst       (burst),
        .i_arrival     (arrival),
        .i_user_class  (user_class),
        .i_last_job    (last_job),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_job_id      (job_id),
        .i_start_time  (start_time),
        .i_end_time    (end_time),
        .i_waiting     (waiting),
        .i_turnaround  (turnaround),
        .i_response    (response),
        .i_last_result (last_result),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: one fresh stall decision per cycle, at the current phase rate
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: ends a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one job word. Idle cycles come first with valid low; once valid
    // is raised the payload holds until the block takes the word.
    task automatic send_job(input logic [BURST_W-1:0] b, input logic [ARR_W-1:0] a,
                            input logic c, input logic l);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        burst      <= b;
        arrival    <= a;
        user_class <= c;
        last_job   <= l;
        do @(posedge i_clk); while (in_stall);
        jobs_sent++;
    endtask

    // One random job set. Sizes cover the whole range; now and then the set
    // overruns capacity so the extra jobs are dropped. Arrival spread picks
    // between heavy ties, close contention and wide idle gaps.
    task automatic send_random_set();
        int                 set_size;
        int                 spread;
        logic [BURST_W-1:0] b;
        logic [ARR_W-1:0]   a;
        if ($urandom_range(9) == 0) begin
            set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
        end else begin
            set_size = $urandom_range(1, MAX_JOBS);
        end
        spread = $urandom_range(3);
        for (int j = 0; j < set_size; j++) begin
            case ($urandom_range(19))
                0: begin
                    b = '0;
                end
                1, 2: begin
                    b = BURST_W'($urandom);
                end
                default: begin
                    b = BURST_W'($urandom_range(1, 64));
                end
            endcase
            case (spread)
                0: begin
                    a = ARR_W'($urandom);
                end
                1: begin
                    a = ARR_W'($urandom_range(0, 3));
                end
                default: begin
                    a = ARR_W'($urandom_range(0, 400));
                end
            endcase
            send_job(b, a, 1'($urandom_range(1)), j == set_size - 1);
        end
    endtask

    initial begin
        in_valid   <= 1'b0;
        burst      <= '0;
        arrival    <= '0;
        user_class <= 1'b0;
        last_job   <= 1'b0;
        i_rst_n    <= 1'b0;
        stall_pct  <= 0;
        idle_pct   = 0;
        jobs_sent  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single job with zero burst: starts and ends on the same tick
        send_job(16'd0, 16'd0, 1'b0, 1'b1);
        // field extremes; system job beats the user job that arrived with it
        send_job(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_job(16'd1, 16'd0, 1'b1, 1'b0);
        send_job(16'd5, 16'd0, 1'b0, 1'b1);
        // nothing ready at tick 0: clock idles to the first arrival
        send_job(16'd10, 16'd100, 1'b0, 1'b0);
        send_job(16'd3, 16'd5, 1'b1, 1'b1);
        // same class and arrival: load order decides
        send_job(16'd4, 16'd7, 1'b1, 1'b0);
        send_job(16'd2, 16'd7, 1'b1, 1'b1);
        // full set plus one: the extra job is dropped, its last flag still counts
        for (int j = 0; j <= MAX_JOBS; j++) begin
            send_job(BURST_W'($urandom_range(1, 9)), ARR_W'($urandom_range(0, 30)),
                     1'(j % 2), j == MAX_JOBS);
        end

        // random sets, rotating through the idling phases set by set
        jobs_sent = 0;
        for (int set_idx = 0; jobs_sent < JOB_TARGET; set_idx++) begin
            idle_pct  = idle_by_phase[set_idx % 4];
            stall_pct <= stall_by_phase[set_idx % 4];
            send_random_set();
        end
        in_valid <= 1'b0;

        // drain the last schedule, then leave room for any stray word
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tlfs_pkg.sv
rtl/tlfs_ram.sv
rtl/tlfs_pick.sv
rtl/two_level_fcfs_scheduler_unit.sv
tb/fcfs_schedule_checker.sv
tb/tb_two_level_fcfs_scheduler_unit.sv
